// File: sv/spa_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the spin projection accumulator.
package spa_pkg;

    localparam int SPIN_WIDTH_DEF = 32;

    localparam int MUL_A_W = 64;
    localparam int MUL_B_W = 33;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int DIV_W   = 64;
    localparam int DIV_CNT_W = 7;

    localparam logic [32:0] LOG2E_Q32 = 33'h1_7154_7653;
    localparam logic [31:0] LN2_Q32   = 32'hB172_17F8;
    localparam logic [38:0] XCAP      = 39'h40_0000_0000;

    localparam logic [1:0] FUNC_LINK  = 2'd0;
    localparam logic [1:0] FUNC_BEGIN = 2'd1;
    localparam logic [1:0] FUNC_END   = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [2:0] REG_AXIS   = 3'd0;
    localparam logic [2:0] REG_GAUSS  = 3'd1;
    localparam logic [2:0] REG_NORM   = 3'd2;
    localparam logic [2:0] REG_INVLSQ = 3'd3;
    localparam logic [2:0] REG_SLICES = 3'd4;

    typedef struct packed {
        logic                 start;
        logic [MUL_A_W-1:0]   a;
        logic [MUL_B_W-1:0]   b;
    } mul_req_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     rem0;
        logic [DIV_W-1:0]     dvd;
        logic [DIV_W-1:0]     dvsr;
        logic [DIV_CNT_W-1:0] steps;
    } div_req_t;

    // Saturating signed add; bit 64 flags saturation.
    function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        logic        ovf;
        r   = a + b;
        ovf = (a[63] == b[63]) && (r[63] != a[63]);
        if (ovf) begin
            return {1'b1, (a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF)};
        end
        return {1'b0, r};
    endfunction

endpackage

// File: sv/spa_mul.sv
`timescale 1ns / 1ps
// Radix-2 shift-and-add multiplier, one bit of operand b per cycle.
module spa_mul (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  spa_pkg::mul_req_t               req,
    output logic [spa_pkg::MUL_P_W-1:0]     prod,
    output logic                            done
);

    logic [spa_pkg::MUL_A_W-1:0] a_reg;
    logic [spa_pkg::MUL_B_W-1:0] b_reg;
    logic [spa_pkg::MUL_P_W-1:0] p_reg;
    logic [5:0]                  cnt_reg;
    logic                        done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                a_reg   <= req.a;
                b_reg   <= req.b;
                p_reg   <= '0;
                cnt_reg <= 6'(spa_pkg::MUL_B_W);
            end else if (cnt_reg != 6'd0) begin
                // MSB first: shift the partial product, add a where the bit is set
                p_reg    <= {p_reg[spa_pkg::MUL_P_W-2:0], 1'b0}
                          + (b_reg[spa_pkg::MUL_B_W-1] ? spa_pkg::MUL_P_W'(a_reg)
                                                       : spa_pkg::MUL_P_W'(0));
                b_reg    <= {b_reg[spa_pkg::MUL_B_W-2:0], 1'b0};
                cnt_reg  <= cnt_reg - 6'd1;
                done_reg <= (cnt_reg == 6'd1);
            end
        end
    end

    assign prod = p_reg;
    assign done = done_reg;

endmodule

// File: sv/spa_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, with a preloadable remainder.
module spa_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  spa_pkg::div_req_t             req,
    output logic [spa_pkg::DIV_W-1:0]     quo,
    output logic                          done
);

    logic [spa_pkg::DIV_W-1:0]     rem_reg;
    logic [spa_pkg::DIV_W-1:0]     dvd_reg;
    logic [spa_pkg::DIV_W-1:0]     dvsr_reg;
    logic [spa_pkg::DIV_W-1:0]     quo_reg;
    logic [spa_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          done_reg;
    logic [spa_pkg::DIV_W:0]       trial;
    logic [spa_pkg::DIV_W:0]       diff;
    logic                          ge;

    always_comb begin
        trial = {rem_reg, dvd_reg[spa_pkg::DIV_W-1]};
        diff  = trial - {1'b0, dvsr_reg};
        ge    = trial >= {1'b0, dvsr_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                rem_reg  <= req.rem0;
                dvd_reg  <= req.dvd;
                dvsr_reg <= req.dvsr;
                quo_reg  <= '0;
                cnt_reg  <= req.steps;
            end else if (cnt_reg != '0) begin
                rem_reg  <= ge ? diff[spa_pkg::DIV_W-1:0] : trial[spa_pkg::DIV_W-1:0];
                dvd_reg  <= {dvd_reg[spa_pkg::DIV_W-2:0], 1'b0};
                quo_reg  <= {quo_reg[spa_pkg::DIV_W-2:0], ge};
                cnt_reg  <= cnt_reg - spa_pkg::DIV_CNT_W'(1);
                done_reg <= (cnt_reg == spa_pkg::DIV_CNT_W'(1));
            end
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

// File: sv/spin_projection_accumulator.sv
`timescale 1ns / 1ps
// Top level: configuration registers, link sequencer and accumulators.
//
// One request at a time. A link request runs a sequencer over one shared
// 33-step shift-add multiplier and one bit-serial divider: a normalize loop
// that halves all magnitudes until each is below 2^30, 8 to 10 multiplies
// (squares, axis products, exponent argument), a 13-term Taylor series with
// one multiply and one 32-step divide per term, the ratio divide when the
// projection is smaller than the norm, and two scaling multiplies. A link with
// zero norm or axis three stops after the squares and any axis products. An
// end request runs a 64-step divide by slice_count; begin and unused codes go
// straight to the output register. The result waits in the output register
// until taken.
module spin_projection_accumulator #(
    parameter int SPIN_WIDTH = spa_pkg::SPIN_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [4:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_func,
    input  logic [SPIN_WIDTH-1:0]  s_spin_a,
    input  logic [SPIN_WIDTH-1:0]  s_spin_b,
    input  logic [SPIN_WIDTH-1:0]  s_spin_c,
    input  logic [SPIN_WIDTH-1:0]  s_spin_d,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [63:0]            m_slice_total,
    output logic [63:0]            m_grand_total,
    output logic [31:0]            m_measure_count,
    output logic                   m_zero_norm,
    output logic                   m_saturated
);

    localparam int SH_W = 6;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SHIFT = 5'b00010,
        ST_MUL   = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    typedef enum logic [3:0] {
        OP_SQ, OP_PA, OP_PB, OP_X1, OP_X2, OP_Y, OP_U, OP_T, OP_A, OP_M,
        OP_DT, OP_DR, OP_DE
    } op_t;

    state_t state_reg;
    op_t    op_reg;
    logic   wait_reg;

    logic [1:0]  axis_reg;
    logic [31:0] gauss_reg;
    logic [31:0] norm_reg;
    logic [31:0] invl_reg;
    logic [15:0] slices_reg;

    logic [63:0] slice_reg;
    logic [63:0] total_reg;
    logic [31:0] count_reg;
    logic        zero_reg;
    logic        sat_reg;

    logic [SPIN_WIDTH-1:0] mag_reg [4];
    logic [3:0]            neg_reg;
    logic [SH_W-1:0]       sh_reg;
    logic [1:0]            j_reg;
    logic [63:0]           q_reg;
    logic signed [63:0]    p_reg;
    logic [63:0]           x_reg;
    logic [6:0]            n_reg;
    logic [31:0]           u_reg;
    logic [32:0]           term_reg;
    logic [33:0]           sum_reg;
    logic [3:0]            k_reg;
    logic [33:0]           e_reg;
    logic [32:0]           r_reg;
    logic [33:0]           a3_reg;

    spa_pkg::mul_req_t           mreq;
    spa_pkg::div_req_t           dreq;
    logic [spa_pkg::MUL_P_W-1:0] prod;
    logic                        mul_done;
    logic [63:0]                 quo;
    logic                        div_done;

    logic [SPIN_WIDTH-1:0] spin_in [4];
    logic [SPIN_WIDTH-1:0] mag_in [4];
    logic                  big;
    logic                  cfg_wr;
    logic                  skip_zero;
    logic                  skip;
    logic [59:0]           prod60;
    logic                  psign;
    logic [63:0]           sprod;
    logic [72:0]           t73;
    logic [38:0]           x2;
    logic [38:0]           lim;
    logic [38:0]           x3;
    logic                  pneg;
    logic [63:0]           pm;
    logic [33:0]           tq;
    logic [33:0]           sum_new;
    logic [63:0]           mval;
    logic [64:0]           link_add;
    logic                  sneg;
    logic [63:0]           mg;
    logic [63:0]           avg;
    logic [64:0]           end_add;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        case (paddr[4:2])
            spa_pkg::REG_AXIS:   prdata = {30'd0, axis_reg};
            spa_pkg::REG_GAUSS:  prdata = gauss_reg;
            spa_pkg::REG_NORM:   prdata = norm_reg;
            spa_pkg::REG_INVLSQ: prdata = invl_reg;
            spa_pkg::REG_SLICES: prdata = {16'd0, slices_reg};
            default:             prdata = 32'd0;
        endcase
    end

    always_comb begin
        spin_in[0] = s_spin_a;
        spin_in[1] = s_spin_b;
        spin_in[2] = s_spin_c;
        spin_in[3] = s_spin_d;
        for (int i = 0; i < 4; i++) begin
            mag_in[i] = spin_in[i][SPIN_WIDTH-1] ? (~spin_in[i] + 1'b1) : spin_in[i];
        end
        big = 1'b0;
        for (int i = 0; i < 4; i++) begin
            big = big || (64'(mag_reg[i]) >= 64'h4000_0000);
        end
    end

    // Link datapath helpers
    always_comb begin
        skip_zero = (q_reg == 64'd0) || (invl_reg == 32'd0);
        skip      = (op_reg == OP_X1) && (skip_zero || (axis_reg == 2'd3));
        prod60    = prod[59:0];
        if (op_reg == OP_PA) begin
            psign = (axis_reg == spa_pkg::AXIS_X) ? (neg_reg[1] ^ neg_reg[3])
                                                  : (neg_reg[0] ^ neg_reg[1]);
        end else begin
            psign = (axis_reg == spa_pkg::AXIS_X) ? (neg_reg[0] ^ neg_reg[2])
                                                  : (neg_reg[2] ^ neg_reg[3]);
        end
        sprod = psign ? (64'd0 - 64'(prod60)) : 64'(prod60);
        t73   = prod[96:24];
        x2    = (t73 > 73'(spa_pkg::XCAP)) ? spa_pkg::XCAP : t73[38:0];
        lim   = spa_pkg::XCAP >> {sh_reg, 1'b0};
        x3    = (x2 > lim) ? spa_pkg::XCAP : (x2 << {sh_reg, 1'b0});
        pneg  = p_reg[63];
        pm    = pneg ? (64'd0 - p_reg) : p_reg;
        tq    = 34'(quo[31:0]);
        if (k_reg[0]) begin
            sum_new = (sum_reg >= tq) ? (sum_reg - tq) : 34'd0;
        end else begin
            sum_new = sum_reg + tq;
        end
        mval     = 64'(prod[66:25]);
        link_add = spa_pkg::sat_add(slice_reg, pneg ? (64'd0 - mval) : mval);
        sneg     = slice_reg[63];
        mg       = sneg ? (64'd0 - slice_reg) : slice_reg;
        avg      = sneg ? (64'd0 - quo) : quo;
        end_add  = spa_pkg::sat_add(total_reg, avg);
    end

    always_comb begin
        mreq       = '0;
        mreq.start = (state_reg == ST_MUL) && !wait_reg && !skip;
        case (op_reg)
            OP_SQ: begin
                mreq.a = 64'(mag_reg[j_reg]);
                mreq.b = 33'(mag_reg[j_reg]);
            end
            OP_PA: begin
                mreq.a = (axis_reg == spa_pkg::AXIS_X) ? 64'(mag_reg[1]) : 64'(mag_reg[0]);
                mreq.b = (axis_reg == spa_pkg::AXIS_X) ? 33'(mag_reg[3]) : 33'(mag_reg[1]);
            end
            OP_PB: begin
                mreq.a = (axis_reg == spa_pkg::AXIS_X) ? 64'(mag_reg[0]) : 64'(mag_reg[2]);
                mreq.b = (axis_reg == spa_pkg::AXIS_X) ? 33'(mag_reg[2]) : 33'(mag_reg[3]);
            end
            OP_X1: begin
                mreq.a = q_reg;
                mreq.b = 33'(invl_reg);
            end
            OP_X2: begin
                mreq.a = x_reg;
                mreq.b = 33'(gauss_reg);
            end
            OP_Y: begin
                mreq.a = x_reg;
                mreq.b = spa_pkg::LOG2E_Q32;
            end
            OP_U: begin
                mreq.a = 64'(u_reg);
                mreq.b = 33'(spa_pkg::LN2_Q32);
            end
            OP_T: begin
                mreq.a = 64'(term_reg);
                mreq.b = 33'(u_reg);
            end
            OP_A: begin
                mreq.a = 64'(e_reg);
                mreq.b = 33'(norm_reg);
            end
            OP_M: begin
                mreq.a = 64'(a3_reg);
                mreq.b = r_reg;
            end
            default: begin
                mreq.a = '0;
                mreq.b = '0;
            end
        endcase
    end

    always_comb begin
        dreq       = '0;
        dreq.start = (state_reg == ST_DIV) && !wait_reg;
        case (op_reg)
            OP_DT: begin
                dreq.dvd   = {term_reg[31:0], 32'd0};
                dreq.dvsr  = 64'(k_reg);
                dreq.steps = 7'd32;
            end
            OP_DR: begin
                dreq.rem0  = pm;
                dreq.dvsr  = q_reg;
                dreq.steps = 7'd32;
            end
            OP_DE: begin
                dreq.dvd   = mg;
                dreq.dvsr  = (slices_reg == 16'd0) ? 64'd1 : 64'(slices_reg);
                dreq.steps = 7'd64;
            end
            default: begin
                dreq.steps = '0;
            end
        endcase
    end

    spa_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .prod    (prod),
        .done    (mul_done)
    );

    spa_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .quo     (quo),
        .done    (div_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            op_reg     <= OP_SQ;
            wait_reg   <= 1'b0;
            axis_reg   <= 2'd0;
            gauss_reg  <= 32'd0;
            norm_reg   <= 32'h0100_0000;
            invl_reg   <= 32'h0001_0000;
            slices_reg <= 16'd1;
            slice_reg  <= 64'd0;
            total_reg  <= 64'd0;
            count_reg  <= 32'd0;
            zero_reg   <= 1'b0;
            sat_reg    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[4:2])
                    spa_pkg::REG_AXIS:   axis_reg   <= pwdata[1:0];
                    spa_pkg::REG_GAUSS:  gauss_reg  <= pwdata;
                    spa_pkg::REG_NORM:   norm_reg   <= pwdata;
                    spa_pkg::REG_INVLSQ: invl_reg   <= pwdata;
                    spa_pkg::REG_SLICES: slices_reg <= pwdata[15:0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        zero_reg <= 1'b0;
                        sat_reg  <= 1'b0;
                        wait_reg <= 1'b0;
                        case (s_func)
                            spa_pkg::FUNC_LINK: begin
                                for (int i = 0; i < 4; i++) begin
                                    mag_reg[i] <= mag_in[i];
                                    neg_reg[i] <= spin_in[i][SPIN_WIDTH-1];
                                end
                                sh_reg    <= '0;
                                j_reg     <= 2'd0;
                                q_reg     <= 64'd0;
                                p_reg     <= 64'sd0;
                                op_reg    <= OP_SQ;
                                state_reg <= ST_SHIFT;
                            end
                            spa_pkg::FUNC_BEGIN: begin
                                slice_reg <= 64'd0;
                                state_reg <= ST_OUT;
                            end
                            spa_pkg::FUNC_END: begin
                                op_reg    <= OP_DE;
                                state_reg <= ST_DIV;
                            end
                            default: state_reg <= ST_OUT;
                        endcase
                    end
                end
                ST_SHIFT: begin
                    // Scale down until every magnitude is below 2^30
                    if (big) begin
                        for (int i = 0; i < 4; i++) begin
                            mag_reg[i] <= mag_reg[i] >> 1;
                        end
                        sh_reg <= sh_reg + 1'b1;
                    end else begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (!wait_reg) begin
                        if (skip) begin
                            zero_reg  <= skip_zero;
                            state_reg <= ST_OUT;
                        end else begin
                            wait_reg <= 1'b1;
                        end
                    end else if (mul_done) begin
                        wait_reg <= 1'b0;
                        case (op_reg)
                            OP_SQ: begin
                                q_reg <= q_reg + 64'(prod60);
                                if (axis_reg == spa_pkg::AXIS_Z) begin
                                    p_reg <= (j_reg == 2'd0 || j_reg == 2'd3)
                                           ? p_reg + 64'(prod60) : p_reg - 64'(prod60);
                                end
                                if (j_reg == 2'd3) begin
                                    op_reg <= (axis_reg == spa_pkg::AXIS_X ||
                                               axis_reg == spa_pkg::AXIS_Y) ? OP_PA : OP_X1;
                                end else begin
                                    j_reg <= j_reg + 2'd1;
                                end
                            end
                            OP_PA: begin
                                p_reg  <= p_reg + sprod;
                                op_reg <= OP_PB;
                            end
                            OP_PB: begin
                                p_reg  <= (axis_reg == spa_pkg::AXIS_X)
                                        ? ((p_reg - sprod) <<< 1) : ((p_reg + sprod) <<< 1);
                                op_reg <= OP_X1;
                            end
                            OP_X1: begin
                                x_reg  <= 64'(prod[93:32]);
                                op_reg <= OP_X2;
                            end
                            OP_X2: begin
                                x_reg  <= 64'(x3);
                                op_reg <= OP_Y;
                            end
                            OP_Y: begin
                                n_reg  <= prod[70:64];
                                u_reg  <= prod[63:32];
                                op_reg <= OP_U;
                            end
                            OP_U: begin
                                u_reg    <= prod[63:32];
                                term_reg <= 33'h1_0000_0000;
                                sum_reg  <= 34'h1_0000_0000;
                                k_reg    <= 4'd1;
                                op_reg   <= OP_T;
                            end
                            OP_T: begin
                                term_reg  <= 33'(prod[63:32]);
                                op_reg    <= OP_DT;
                                state_reg <= ST_DIV;
                            end
                            OP_A: begin
                                a3_reg <= {1'b0, prod[63:32], 1'b0} + 34'(prod[63:32]);
                                op_reg <= OP_M;
                            end
                            OP_M: begin
                                slice_reg <= link_add[63:0];
                                sat_reg   <= link_add[64];
                                state_reg <= ST_OUT;
                            end
                            default: state_reg <= ST_OUT;
                        endcase
                    end
                end
                ST_DIV: begin
                    if (!wait_reg) begin
                        wait_reg <= 1'b1;
                    end else if (div_done) begin
                        wait_reg <= 1'b0;
                        case (op_reg)
                            OP_DT: begin
                                term_reg <= 33'(quo[31:0]);
                                sum_reg  <= sum_new;
                                if (k_reg == 4'd13) begin
                                    e_reg <= n_reg[6] ? 34'd0 : (sum_new >> n_reg[5:0]);
                                    if (pm >= q_reg) begin
                                        r_reg     <= 33'h1_0000_0000;
                                        op_reg    <= OP_A;
                                        state_reg <= ST_MUL;
                                    end else begin
                                        op_reg <= OP_DR;
                                    end
                                end else begin
                                    k_reg     <= k_reg + 4'd1;
                                    op_reg    <= OP_T;
                                    state_reg <= ST_MUL;
                                end
                            end
                            OP_DR: begin
                                r_reg     <= 33'(quo[31:0]);
                                op_reg    <= OP_A;
                                state_reg <= ST_MUL;
                            end
                            OP_DE: begin
                                slice_reg <= avg;
                                total_reg <= end_add[63:0];
                                sat_reg   <= end_add[64];
                                count_reg <= count_reg + 32'd1;
                                state_reg <= ST_OUT;
                            end
                            default: state_reg <= ST_OUT;
                        endcase
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = (state_reg == ST_OUT);
    assign m_slice_total   = slice_reg;
    assign m_grand_total   = total_reg;
    assign m_measure_count = count_reg;
    assign m_zero_norm     = zero_reg;
    assign m_saturated     = sat_reg;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready held after accepting a request");

    a_zero_no_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_norm |-> !m_saturated)
        else $error("zero-norm link reported saturation");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && $rose(m_valid) && (m_measure_count != $past(m_measure_count))
        |-> m_measure_count == $past(m_measure_count) + 32'd1)
        else $error("measurement count moved by more than one");

endmodule

// File: dv/spa_checker.sv
`timescale 1ns / 1ps
// Checker: tracks register writes, predicts each result and compares it on the output channel.
module spa_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [31:0] s_spin_a,
    input  logic [31:0] s_spin_b,
    input  logic [31:0] s_spin_c,
    input  logic [31:0] s_spin_d,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [63:0] m_slice_total,
    input  logic [63:0] m_grand_total,
    input  logic [31:0] m_measure_count,
    input  logic        m_zero_norm,
    input  logic        m_saturated,
    output int          mismatches,
    output int          outstanding,
    output int          checked
);

    typedef struct packed {
        logic [63:0] slice_total;
        logic [63:0] grand_total;
        logic [31:0] measure_count;
        logic        zero_norm;
        logic        saturated;
    } spa_result_t;

    localparam logic [63:0] SAT_POS  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_NEG  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] EXP_CAP  = 64'h40_0000_0000;
    localparam logic [63:0] ALL_ONES = '1;

    spa_result_t expected_results[$];

    logic [1:0]  cfg_axis;
    logic [31:0] cfg_gauss;
    logic [31:0] cfg_norm;
    logic [31:0] cfg_invlsq;
    logic [15:0] cfg_slices;

    logic [63:0] slice_sum;
    logic [63:0] total_sum;
    logic [31:0] meas_cnt;

    // (a*b) >> s over the full product, clamped at cap
    function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                              input int s, input logic [63:0] cap);
        logic [127:0] prod;
        logic [127:0] shifted;
        prod    = {64'd0, a} * {64'd0, b};
        shifted = prod >> s;
        if (shifted[127:64] != 0) return cap;
        return (shifted[63:0] > cap) ? cap : shifted[63:0];
    endfunction

    function automatic logic [63:0] sum_clamped(input logic [63:0] a, input logic [63:0] b,
                                                inout logic sat);
        logic [63:0] r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63]) begin
            sat = 1'b1;
            return a[63] ? SAT_NEG : SAT_POS;
        end
        return r;
    endfunction

    function automatic logic [63:0] gauss_decay(input logic [63:0] x);
        logic [63:0] y;
        logic [63:0] n;
        logic [63:0] u;
        logic [63:0] series;
        logic [63:0] term;
        y      = mul_shift(x, 64'h1_7154_7653, 32, ALL_ONES);
        n      = y >> 32;
        u      = ({32'd0, y[31:0]} * 64'hB172_17F8) >> 32;
        series = 64'd1 << 32;
        term   = 64'd1 << 32;
        for (int k = 1; k <= 13; k++) begin
            term = ((term * u) >> 32) / k;
            if (k % 2 == 1) series = (series >= term) ? series - term : 64'd0;
            else            series = series + term;
        end
        return (n >= 64) ? 64'd0 : (series >> n);
    endfunction

    function automatic void project_link(input logic [31:0] sa, input logic [31:0] sb,
                                         input logic [31:0] sc, input logic [31:0] sd,
                                         output logic zero, inout logic sat);
        logic [31:0] raw [4];
        logic [63:0] mag [4];
        logic        neg [4];
        longint      v [4];
        longint      proj;
        logic [63:0] mx;
        logic [63:0] qsum;
        logic [63:0] pm;
        logic [63:0] ratio;
        logic [63:0] rem;
        logic [63:0] x;
        logic [63:0] e;
        logic [63:0] amp;
        logic [63:0] inc;
        int          sh;
        raw[0] = sa; raw[1] = sb; raw[2] = sc; raw[3] = sd;
        zero = 1'b0;
        mx   = 0;
        for (int i = 0; i < 4; i++) begin
            neg[i] = raw[i][31];
            mag[i] = neg[i] ? (64'h1_0000_0000 - {32'd0, raw[i]}) : {32'd0, raw[i]};
            if (mag[i] > mx) mx = mag[i];
        end
        sh = 0;
        while ((mx >> sh) >= (64'd1 << 30)) sh++;
        qsum = 0;
        for (int i = 0; i < 4; i++) begin
            mag[i] = mag[i] >> sh;
            v[i]   = neg[i] ? -longint'(mag[i]) : longint'(mag[i]);
            qsum   = qsum + mag[i] * mag[i];
        end
        if (qsum == 0 || cfg_invlsq == 0) begin
            zero = 1'b1;
            return;
        end
        case (cfg_axis)
            spa_pkg::AXIS_X: proj = 2 * (v[1] * v[3] - v[0] * v[2]);
            spa_pkg::AXIS_Y: proj = 2 * (v[0] * v[1] + v[2] * v[3]);
            spa_pkg::AXIS_Z: proj = v[0] * v[0] - v[1] * v[1] - v[2] * v[2] + v[3] * v[3];
            default: return;
        endcase
        x = mul_shift(qsum, {32'd0, cfg_invlsq}, 32, ALL_ONES);
        x = mul_shift(x, {32'd0, cfg_gauss}, 24, EXP_CAP);
        x = (x > (EXP_CAP >> (2 * sh))) ? EXP_CAP : (x << (2 * sh));
        e = gauss_decay(x);
        pm = (proj < 0) ? 64'(-proj) : 64'(proj);
        if (pm >= qsum) begin
            ratio = 64'd1 << 32;
        end else begin
            rem   = pm;
            ratio = 0;
            for (int i = 0; i < 32; i++) begin
                rem   = rem << 1;
                ratio = ratio << 1;
                if (rem >= qsum) begin
                    rem      = rem - qsum;
                    ratio[0] = 1'b1;
                end
            end
        end
        amp = ({32'd0, cfg_norm} * e) >> 32;
        inc = mul_shift(amp * 3, ratio, 25, ALL_ONES);
        slice_sum = sum_clamped(slice_sum, (proj < 0) ? (64'd0 - inc) : inc, sat);
    endfunction

    function automatic spa_result_t accumulate(input logic [1:0] func, input logic [31:0] sa,
                                               input logic [31:0] sb, input logic [31:0] sc,
                                               input logic [31:0] sd);
        spa_result_t res;
        logic        zero;
        logic        sat;
        logic [63:0] div;
        logic [63:0] mg;
        zero = 1'b0;
        sat  = 1'b0;
        case (func)
            spa_pkg::FUNC_LINK:  project_link(sa, sb, sc, sd, zero, sat);
            spa_pkg::FUNC_BEGIN: slice_sum = 0;
            spa_pkg::FUNC_END: begin
                div       = (cfg_slices == 0) ? 64'd1 : {48'd0, cfg_slices};
                mg        = slice_sum[63] ? (64'd0 - slice_sum) : slice_sum;
                mg        = mg / div;
                slice_sum = slice_sum[63] ? (64'd0 - mg) : mg;
                total_sum = sum_clamped(total_sum, slice_sum, sat);
                meas_cnt  = meas_cnt + 1;
            end
            default: ;
        endcase
        res.slice_total   = slice_sum;
        res.grand_total   = total_sum;
        res.measure_count = meas_cnt;
        res.zero_norm     = zero;
        res.saturated     = sat;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        spa_result_t want;
        if (!aresetn) begin
            cfg_axis   <= spa_pkg::AXIS_X;
            cfg_gauss  <= 32'd0;
            cfg_norm   <= 32'd16777216;
            cfg_invlsq <= 32'd65536;
            cfg_slices <= 16'd1;
            slice_sum  = 0;
            total_sum  = 0;
            meas_cnt   = 0;
            expected_results.delete();
            mismatches  = 0;
            checked     <= 0;
            outstanding <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    spa_pkg::REG_AXIS:   cfg_axis   <= pwdata[1:0];
                    spa_pkg::REG_GAUSS:  cfg_gauss  <= pwdata;
                    spa_pkg::REG_NORM:   cfg_norm   <= pwdata;
                    spa_pkg::REG_INVLSQ: cfg_invlsq <= pwdata;
                    spa_pkg::REG_SLICES: cfg_slices <= pwdata[15:0];
                    default: ;
                endcase
            end
            // pop before push: a result never belongs to a request taken in the same cycle
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", m_slice_total, 64'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_slice_total !== want.slice_total)
                        report_mismatch("slice_total", m_slice_total, want.slice_total);
                    if (m_grand_total !== want.grand_total)
                        report_mismatch("grand_total", m_grand_total, want.grand_total);
                    if (m_measure_count !== want.measure_count)
                        report_mismatch("measure_count", m_measure_count, want.measure_count);
                    if (m_zero_norm !== want.zero_norm)
                        report_mismatch("zero_norm", m_zero_norm, want.zero_norm);
                    if (m_saturated !== want.saturated)
                        report_mismatch("saturated", m_saturated, want.saturated);
                end
                checked <= checked + 1;
            end
            if (s_valid && s_ready)
                expected_results.push_back(accumulate(s_func, s_spin_a, s_spin_b,
                                                      s_spin_c, s_spin_d));
            outstanding <= expected_results.size();
        end
    end

endmodule

// File: dv/tb_spin_projection_accumulator.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, register setup, request stimulus and verdict.
module tb_spin_projection_accumulator;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func = spa_pkg::FUNC_LINK;
    logic [31:0] s_spin_a = '0;
    logic [31:0] s_spin_b = '0;
    logic [31:0] s_spin_c = '0;
    logic [31:0] s_spin_d = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_slice_total;
    logic [63:0] m_grand_total;
    logic [31:0] m_measure_count;
    logic        m_zero_norm;
    logic        m_saturated;

    int mismatches;
    int outstanding;
    int checked;
    int tx_idle_pct = 19;
    int rx_idle_pct = 51;
    logic rx_hold = 1'b0;
    int sent = 0;

    spin_projection_accumulator dut (.*);

    spa_checker checker_i (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    initial begin
        #200_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_request(input logic [1:0] func, input logic [31:0] a,
                                input logic [31:0] b, input logic [31:0] c,
                                input logic [31:0] d);
        s_valid  <= 1'b1;
        s_func   <= func;
        s_spin_a <= a;
        s_spin_b <= b;
        s_spin_c <= c;
        s_spin_d <= d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic configure(input logic [1:0] ax, input logic [31:0] g, input logic [31:0] n,
                             input logic [31:0] l, input logic [15:0] sc);
        write_reg(spa_pkg::REG_AXIS, {30'd0, ax});
        write_reg(spa_pkg::REG_GAUSS, g);
        write_reg(spa_pkg::REG_NORM, n);
        write_reg(spa_pkg::REG_INVLSQ, l);
        write_reg(spa_pkg::REG_SLICES, {16'd0, sc});
    endtask

    function automatic logic [31:0] rand_spin();
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return 32'h8000_0000;
            2:       return 32'h7FFF_FFFF;
            3, 4:    return $urandom_range(32'h0400_0000) - 32'h0200_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_link;
        send_request(spa_pkg::FUNC_LINK, rand_spin(), rand_spin(), rand_spin(), rand_spin());
    endtask

    task automatic run_measurements(input int quota);
        int stop;
        stop = sent + quota;
        while (sent < stop) begin
            if ($urandom_range(9) == 0) begin
                // noise: any code, including the unused one
                send_request(2'($urandom_range(3)), rand_spin(), rand_spin(),
                             rand_spin(), rand_spin());
            end else begin
                send_request(spa_pkg::FUNC_BEGIN, $urandom, $urandom, $urandom, $urandom);
                repeat ($urandom_range(4)) send_link();
                send_request(spa_pkg::FUNC_END, $urandom, $urandom, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset settings first
        send_request(spa_pkg::FUNC_BEGIN, '0, '0, '0, '0);
        send_request(spa_pkg::FUNC_LINK, 32'h0100_0000, '0, '0, '0);
        send_request(spa_pkg::FUNC_LINK, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000,
                     32'h0100_0000);
        send_request(spa_pkg::FUNC_LINK, '0, '0, '0, '0);
        send_request(spa_pkg::FUNC_LINK, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000);
        send_request(spa_pkg::FUNC_LINK, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF);
        send_request(spa_pkg::FUNC_LINK, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
                     32'h0000_0001);
        send_request(spa_pkg::FUNC_END, '0, '0, '0, '0);
        send_request(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();
        configure(spa_pkg::AXIS_Y, 32'h0080_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0);
        send_request(spa_pkg::FUNC_LINK, 32'h0100_0000, 32'h0100_0000, 32'hFF00_0000,
                     32'h0080_0000);
        send_request(spa_pkg::FUNC_LINK, 32'h4000_0000, 32'hC000_0000, 32'h0000_0001, 32'h0);
        send_request(spa_pkg::FUNC_END, '0, '0, '0, '0);
        drain();
        configure(spa_pkg::AXIS_Z, 32'hFFFF_FFFF, 32'd0, 32'd0, 16'hFFFF);
        send_request(spa_pkg::FUNC_LINK, 32'h0100_0000, 32'h0200_0000, '0, '0);
        send_request(spa_pkg::FUNC_END, '0, '0, '0, '0);
        drain();
        configure(2'd3, 32'd0, 32'h0100_0000, 32'h0001_0000, 16'd3);
        send_request(spa_pkg::FUNC_LINK, 32'h0100_0000, 32'h0200_0000, 32'h0300_0000, '0);
        send_request(spa_pkg::FUNC_LINK, '0, '0, '0, '0);
        send_request(spa_pkg::FUNC_END, '0, '0, '0, '0);
        drain();

        for (int phase = 0; phase < 9; phase++) begin
            if (phase == 3) begin
                tx_idle_pct = 51;
                rx_idle_pct = 19;
            end else if (phase == 6) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (phase % 5)
                0: configure(spa_pkg::AXIS_X, $urandom_range(32'h0400_0000), 32'h0100_0000,
                             32'h0001_0000, 16'd1);
                1: configure(spa_pkg::AXIS_Y, $urandom, $urandom, $urandom, 16'($urandom));
                2: configure(spa_pkg::AXIS_Z, $urandom_range(32'h0100_0000), 32'hFFFF_FFFF,
                             $urandom_range(32'h0010_0000), 16'hFFFF);
                3: configure(2'($urandom_range(3)), 32'hFFFF_FFFF, $urandom, 32'hFFFF_FFFF,
                             16'd0);
                default: configure(2'($urandom_range(2)), 32'd0, $urandom,
                                   $urandom_range(32'h0004_0000), 16'($urandom_range(7)));
            endcase
            if (phase == 4) begin
                // stall the receiver long enough to back up the input with short requests
                fork
                    begin
                        rx_hold <= 1'b1;
                        repeat (3000) @(posedge aclk);
                        rx_hold <= 1'b0;
                    end
                join_none
                repeat (12) send_request(spa_pkg::FUNC_BEGIN, $urandom, $urandom, $urandom,
                                         $urandom);
            end
            run_measurements(120);
            drain();
        end

        repeat (20) @(posedge aclk);
        $display("Sent %0d requests over nine register settings plus directed corners.", sent);
        $display("Checked %0d results with %0d mismatches.", checked, mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: files.f
sv/spa_pkg.sv
sv/spa_mul.sv
sv/spa_div.sv
sv/spin_projection_accumulator.sv
dv/spa_checker.sv
dv/tb_spin_projection_accumulator.sv
